FILE: src/pli_pkg.sv
package pli_pkg;

   localparam int VAL_W  = 32;
   localparam int STEP_W = 31;
   localparam int IDX_W  = 10;

   typedef enum logic [1:0] {
      CMD_SET_ACCEL = 2'd0,
      CMD_ADVANCE   = 2'd1,
      CMD_LOAD_POS  = 2'd2,
      CMD_LOAD_VEL  = 2'd3
   } cmd_type;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_READ   = 3'd1,
      OP_DIV    = 3'd2,
      OP_ACC    = 3'd3,
      OP_VEL    = 3'd4,
      OP_POS    = 3'd5,
      OP_WRITE  = 3'd6,
      OP_RESULT = 3'd7
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] axis;
      logic       start;
   } ctl_type;

   typedef struct packed {
      logic busy;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

FILE: src/particle_leapfrog_integrator.sv
// channel | dir | data bits (low first)
// req     | in  | cmd[1:0] index[11:2] vec_xyz[107:12] step[138:108] prev[169:139], pad
// rsp     | out | out_index[9:0], pos_x/y/z[105:10], vel_x/y/z[201:106], zero to 208
// Per transfer: a load reads, writes and outputs; an advance reads, runs three
// phases per axis (acceleration, velocity, position), writes and outputs; set
// acceleration runs three serial divisions, one quotient bit a cycle, skipped
// with a zero time step, then writes and outputs.
// After reset a clearing pass zeroes the accel stores;
// no transfer is taken during it. One item at a time; a stalled result holds
// the block in its output state.
module particle_leapfrog_integrator #(
   parameter int PARTICLES     = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [175:0] req_tdata,  // cmd, particle_index, vec_x..z, time_step, prev_step
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [207:0] rsp_tdata   // out_index, pos_x..z, vel_x..z
);
   pli_pkg::ctl_type ctl;
   pli_pkg::sts_type sts;
   logic load;
   logic [9:0] res_index;
   logic [191:0] res_data;

   pli_ctrl u_ctrl (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_cmd(req_tdata[1:0]), .load, .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .ctl, .sts
   );

   pli_datapath #(.PARTICLES(PARTICLES), .FRACTION_BITS(FRACTION_BITS)) u_dp (
      .clock, .reset, .load, .in_cmd(req_tdata[1:0]), .in_index(req_tdata[11:2]),
      .in_vec(req_tdata[107:12]), .in_step(req_tdata[138:108]),
      .in_prev(req_tdata[169:139]), .ctl, .sts, .res_index, .res_data
   );

   assign rsp_tdata = {6'b0, res_data, res_index};
endmodule

FILE: src/pli_datapath.sv
module pli_datapath #(
   parameter int PARTICLES     = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [1:0]            in_cmd,
   input  logic [9:0]            in_index,
   input  logic [95:0]           in_vec,
   input  logic [30:0]           in_step,
   input  logic [30:0]           in_prev,
   input  pli_pkg::ctl_type      ctl,
   output pli_pkg::sts_type      sts,
   output logic [9:0]            res_index,
   output logic [191:0]          res_data
);
   localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
   localparam int DW = 66;
   localparam int QW = 32 + FRACTION_BITS;

   logic [95:0] pos_mem [PARTICLES];
   logic [95:0] vel_mem [PARTICLES];
   logic [95:0] acc_mem [PARTICLES];
   logic [95:0] rate_mem [PARTICLES];
   // accel and rate reset to zero: per-row epoch-free valid flags are too many,
   // so a clearing sweep runs after reset
   logic [AW:0] clr_ff, clr_in;

   logic [1:0]  cmd_ff;
   logic [9:0]  idx_ff;
   logic [95:0] vec_ff;
   logic [30:0] step_ff, prev_ff;
   logic        oob_ff;
   logic signed [31:0] pos_ff [3], vel_ff [3], acc_ff [3], rate_ff [3];
   logic [95:0] rd_pos_ff, rd_vel_ff, rd_acc_ff, rd_rate_ff;
   logic        rd_wait_ff;

   // serial divider
   logic [DW-1:0] rem_ff, num_ff;
   logic [QW-1:0] quo_ff;
   logic [6:0]    cnt_ff;
   logic          div_busy_ff, div_neg_ff;

   // multiplier stage
   logic signed [31:0] ma;
   logic [31:0]        mb;
   logic [4:0]         msh;
   logic [31:0]        mag;
   logic [63:0]        prod;
   logic [63:0]        rnd;
   logic signed [65:0] addend;

   wire [AW-1:0] addr = AW'(idx_ff);
   wire [1:0]    ax   = ctl.axis;

   assign sts.busy = div_busy_ff | (clr_ff != PARTICLES[AW:0]) | rd_wait_ff;

   always_comb begin
      clr_in = clr_ff;
      if (clr_ff != PARTICLES[AW:0]) clr_in = clr_ff + 1'b1;
   end

   always_comb begin
      ma  = '0;
      mb  = '0;
      msh = 5'(FRACTION_BITS);
      unique case (ctl.op)
         pli_pkg::OP_ACC: begin ma = rate_ff[ax]; mb = {1'b0, step_ff}; end
         pli_pkg::OP_VEL: begin
            ma = acc_ff[ax]; mb = {1'b0, step_ff} + {1'b0, prev_ff};
            msh = 5'(FRACTION_BITS + 1);
         end
         pli_pkg::OP_POS: begin ma = vel_ff[ax]; mb = {1'b0, step_ff}; end
         default: ;
      endcase
      mag  = ma[31] ? 32'(-ma) : ma;
      prod = 64'(mag) * 64'(mb);
      rnd  = (prod + (64'd1 << (msh - 5'd1))) >> msh;
      addend = ma[31] ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         div_busy_ff <= 1'b0;
         rd_wait_ff  <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         if (clr_ff != PARTICLES[AW:0]) begin
            acc_mem[clr_ff[AW-1:0]]  <= '0;
            rate_mem[clr_ff[AW-1:0]] <= '0;
         end
         rd_wait_ff <= (ctl.op == pli_pkg::OP_READ) && !rd_wait_ff;
         if (div_busy_ff) begin
            // one quotient bit a cycle
            cnt_ff <= cnt_ff - 7'd1;
            if ({rem_ff[DW-2:0], quo_ff[QW-1]} >= num_ff) begin
               rem_ff <= {rem_ff[DW-2:0], quo_ff[QW-1]} - num_ff;
               quo_ff <= {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[DW-2:0], quo_ff[QW-1]};
               quo_ff <= {quo_ff[QW-2:0], 1'b0};
            end
            if (cnt_ff == 7'd1) div_busy_ff <= 1'b0;
         end else if (ctl.op == pli_pkg::OP_DIV && ctl.start) begin
            logic signed [33:0] d;
            logic [33:0] dm;
            d  = 34'($signed(vec_ff[32*ax +: 32])) - 34'(acc_ff[ax]);
            dm = d[33] ? 34'(-d) : d;
            div_neg_ff <= d[33];
            quo_ff <= (step_ff == '0) ? '0 : (QW'(dm) << FRACTION_BITS);
            rem_ff <= '0;
            num_ff <= DW'(step_ff);
            cnt_ff <= 7'(QW);
            div_busy_ff <= (step_ff != '0);
         end
      end
      if (load) begin
         cmd_ff  <= in_cmd;
         idx_ff  <= in_index;
         vec_ff  <= in_vec;
         step_ff <= in_step;
         prev_ff <= in_prev;
         oob_ff  <= (32'(in_index) >= PARTICLES);
      end
      if (ctl.op == pli_pkg::OP_READ) begin
         rd_pos_ff  <= pos_mem[addr];
         rd_vel_ff  <= vel_mem[addr];
         rd_acc_ff  <= acc_mem[addr];
         rd_rate_ff <= rate_mem[addr];
      end
      if (rd_wait_ff) begin
         for (int k = 0; k < 3; k++) begin
            pos_ff[k]  <= rd_pos_ff[32*k +: 32];
            vel_ff[k]  <= rd_vel_ff[32*k +: 32];
            acc_ff[k]  <= rd_acc_ff[32*k +: 32];
            rate_ff[k] <= rd_rate_ff[32*k +: 32];
         end
      end
      if (ctl.op == pli_pkg::OP_DIV && !ctl.start && !div_busy_ff) begin
         logic [QW-1:0] q;
         q = quo_ff;
         if (div_neg_ff)
            rate_ff[ax] <= (q > QW'(64'h80000000)) ? 32'sh80000000 : 32'(-q);
         else rate_ff[ax] <= (q > QW'(64'h7fffffff)) ? 32'sh7fffffff : q[31:0];
      end
      if (ctl.op == pli_pkg::OP_ACC) acc_ff[ax] <= pli_pkg::sat32(66'(acc_ff[ax]) + addend);
      if (ctl.op == pli_pkg::OP_VEL) vel_ff[ax] <= pli_pkg::sat32(66'(vel_ff[ax]) + addend);
      if (ctl.op == pli_pkg::OP_POS) pos_ff[ax] <= pli_pkg::sat32(66'(pos_ff[ax]) + addend);
      if (ctl.op == pli_pkg::OP_WRITE && !oob_ff) begin
         unique case (pli_pkg::cmd_type'(cmd_ff))
            pli_pkg::CMD_SET_ACCEL:
               rate_mem[addr] <= {rate_ff[2], rate_ff[1], rate_ff[0]};
            pli_pkg::CMD_ADVANCE: begin
               acc_mem[addr] <= {acc_ff[2], acc_ff[1], acc_ff[0]};
               vel_mem[addr] <= {vel_ff[2], vel_ff[1], vel_ff[0]};
               pos_mem[addr] <= {pos_ff[2], pos_ff[1], pos_ff[0]};
            end
            pli_pkg::CMD_LOAD_POS: begin
               pos_mem[addr] <= vec_ff;
               for (int k = 0; k < 3; k++) pos_ff[k] <= vec_ff[32*k +: 32];
            end
            pli_pkg::CMD_LOAD_VEL: begin
               vel_mem[addr] <= vec_ff;
               for (int k = 0; k < 3; k++) vel_ff[k] <= vec_ff[32*k +: 32];
            end
         endcase
      end
      if (ctl.op == pli_pkg::OP_RESULT) begin
         res_index <= idx_ff;
         res_data  <= oob_ff ? '0 : {vel_ff[2], vel_ff[1], vel_ff[0],
                                     pos_ff[2], pos_ff[1], pos_ff[0]};
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (ctl.op == pli_pkg::OP_DIV && ctl.start && step_ff != '0) |=> div_busy_ff)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> (cnt_ff != 7'd0))
      else $error("divider count ran out");
   assert property (@(posedge clock) disable iff (reset)
      (ctl.op == pli_pkg::OP_RESULT && oob_ff) |=> (res_data == '0))
      else $error("out-of-range result not cleared");
endmodule

FILE: src/pli_ctrl.sv
module pli_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [1:0]       in_cmd,
   output logic             load,
   output logic             out_valid,
   input  logic             out_ready,
   output pli_pkg::ctl_type ctl,
   input  pli_pkg::sts_type sts
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_READ  = 7'b0000010,
      S_DIVGO = 7'b0000100,
      S_DIVW  = 7'b0001000,
      S_ADV   = 7'b0010000,
      S_WRITE = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in, phase_ff, phase_in;
   logic [1:0] cmd_ff;
   logic out_valid_ff, out_valid_in;

   wire can_take = !out_valid_ff || out_ready;
   assign in_ready  = (state_ff == S_IDLE) && !sts.busy;
   assign load      = in_valid && in_ready;
   assign out_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      phase_in = phase_ff;
      out_valid_in = out_valid_ff && !out_ready;
      ctl = '{op: pli_pkg::OP_NONE, axis: axis_ff, start: 1'b0};
      unique case (state_ff)
         S_IDLE: if (load) begin state_in = S_READ; axis_in = '0; end
         S_READ: begin
            ctl.op = pli_pkg::OP_READ;
            if (sts.busy) begin
               ctl.op = pli_pkg::OP_NONE;
               unique case (pli_pkg::cmd_type'(cmd_ff))
                  pli_pkg::CMD_SET_ACCEL: state_in = S_DIVGO;
                  pli_pkg::CMD_ADVANCE: begin state_in = S_ADV; phase_in = '0; end
                  default: state_in = S_WRITE;
               endcase
            end
         end
         S_DIVGO: begin
            ctl.op = pli_pkg::OP_DIV; ctl.start = 1'b1; state_in = S_DIVW;
         end
         S_DIVW: if (!sts.busy) begin
            ctl.op = pli_pkg::OP_DIV;
            if (axis_ff == 2'd2) state_in = S_WRITE;
            else begin axis_in = axis_ff + 2'd1; state_in = S_DIVGO; end
         end
         S_ADV: begin
            unique case (phase_ff)
               2'd0: ctl.op = pli_pkg::OP_ACC;
               2'd1: ctl.op = pli_pkg::OP_VEL;
               default: ctl.op = pli_pkg::OP_POS;
            endcase
            if (phase_ff == 2'd2) begin
               phase_in = '0;
               if (axis_ff == 2'd2) state_in = S_WRITE;
               else axis_in = axis_ff + 2'd1;
            end else phase_in = phase_ff + 2'd1;
         end
         S_WRITE: begin ctl.op = pli_pkg::OP_WRITE; state_in = S_OUT; end
         S_OUT: if (can_take) begin
            ctl.op = pli_pkg::OP_RESULT; out_valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; axis_ff <= '0; phase_ff <= '0; out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; axis_ff <= axis_in; phase_ff <= phase_in;
         out_valid_ff <= out_valid_in;
      end
      if (load) cmd_ff <= in_cmd;
   end

   assert property (@(posedge clock) disable iff (reset)
      load |=> (state_ff == S_READ))
      else $error("transfer did not start work");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> out_valid_ff)
      else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !in_ready)
      else $error("ready while busy");
endmodule

FILE: verif/particle_leapfrog_checker.sv
`timescale 1ns / 1ps

// Passive checker: watches both channels, keeps its own copy of the particle
// store, predicts the state returned for every request and compares it with
// the response stream in order.
module particle_leapfrog_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [175:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [207:0] rsp_tdata,
   output int           fail_count,
   output int           pending,
   output int           cmd_seen [4]
);

   localparam int NPART = 1024;
   localparam int FRAC  = 16;

   typedef struct {
      logic [9:0]         index;
      logic signed [31:0] pos [3];
      logic signed [31:0] vel [3];
      logic               pos_known;
      logic               vel_known;
   } particle_state_type;

   logic signed [31:0] pos_mem   [NPART][3];
   logic signed [31:0] vel_mem   [NPART][3];
   logic signed [31:0] accel_mem [NPART][3];
   logic signed [31:0] rate_mem  [NPART][3];
   logic               pos_known [NPART];
   logic               vel_known [NPART];

   particle_state_type state_queue[$];

   function automatic logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // scaled product, rounded to nearest with ties away from zero
   function automatic longint scale_round(logic signed [31:0] a, logic [32:0] b, int sh);
      longint     sa;
      logic [63:0] mag, prod, r;
      sa   = a;
      mag  = (sa < 0) ? 64'(-sa) : 64'(sa);
      prod = mag * {31'd0, b};
      r    = (prod + (64'd1 << (sh - 1))) >> sh;
      return (sa < 0) ? -longint'(r) : longint'(r);
   endfunction

   // (difference << FRAC) / dt, truncated toward zero, saturated
   function automatic logic signed [31:0] accel_rate(longint diff, logic [30:0] dt);
      logic [63:0] mag, q;
      if (dt == 0) return '0;
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      q   = (mag << FRAC) / {33'd0, dt};
      if (diff < 0) begin
         if (q > 64'h80000000) return 32'sh80000000;
         return clip32(-longint'(q));
      end
      if (q > 64'h7fffffff) return 32'sh7fffffff;
      return q[31:0];
   endfunction

   function automatic particle_state_type integrate(logic [175:0] d);
      particle_state_type s;
      pli_pkg::cmd_type   cmd;
      int                 idx;
      logic signed [31:0] vec [3];
      logic [30:0]        dt, prev;
      cmd  = pli_pkg::cmd_type'(d[1:0]);
      idx  = int'(d[11:2]);
      dt   = d[138:108];
      prev = d[169:139];
      for (int k = 0; k < 3; k++) vec[k] = d[12 + 32*k +: 32];
      for (int k = 0; k < 3; k++) begin
         case (cmd)
            pli_pkg::CMD_SET_ACCEL: begin
               rate_mem[idx][k] = accel_rate(longint'(vec[k]) - longint'(accel_mem[idx][k]), dt);
            end
            pli_pkg::CMD_ADVANCE: begin
               accel_mem[idx][k] = clip32(longint'(accel_mem[idx][k])
                                          + scale_round(rate_mem[idx][k], {2'b0, dt}, FRAC));
               vel_mem[idx][k] = clip32(longint'(vel_mem[idx][k])
                                        + scale_round(accel_mem[idx][k],
                                                      {2'b0, dt} + {2'b0, prev}, FRAC + 1));
               pos_mem[idx][k] = clip32(longint'(pos_mem[idx][k])
                                        + scale_round(vel_mem[idx][k], {2'b0, dt}, FRAC));
            end
            pli_pkg::CMD_LOAD_POS: pos_mem[idx][k] = vec[k];
            default:               vel_mem[idx][k] = vec[k];
         endcase
      end
      if (cmd == pli_pkg::CMD_LOAD_POS) pos_known[idx] = 1'b1;
      if (cmd == pli_pkg::CMD_LOAD_VEL) vel_known[idx] = 1'b1;
      s.index     = 10'(idx);
      s.pos_known = pos_known[idx];
      s.vel_known = vel_known[idx];
      for (int k = 0; k < 3; k++) begin
         s.pos[k] = pos_mem[idx][k];
         s.vel[k] = vel_mem[idx][k];
      end
      return s;
   endfunction

   function automatic void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t checker: %s mismatch, expected %h, got %h", $realtime, what, exp_v,
                  act_v);
   endfunction

   initial begin
      fail_count = 0;
      for (int c = 0; c < 4; c++) cmd_seen[c] = 0;
      for (int i = 0; i < NPART; i++) begin
         pos_known[i] = 1'b0;
         vel_known[i] = 1'b0;
         for (int k = 0; k < 3; k++) begin
            pos_mem[i][k]   = '0;
            vel_mem[i][k]   = '0;
            accel_mem[i][k] = '0;
            rate_mem[i][k]  = '0;
         end
      end
   end

   always @(posedge clock) begin
      particle_state_type s;
      if (!reset && req_tvalid && req_tready) begin
         state_queue.push_back(integrate(req_tdata));
         cmd_seen[req_tdata[1:0]]++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (state_queue.size() == 0) begin
            report("unexpected response, index", 'x, 32'(rsp_tdata[9:0]));
         end else begin
            s = state_queue.pop_front();
            if (rsp_tdata[9:0] !== s.index)
               report("index", 32'(s.index), 32'(rsp_tdata[9:0]));
            // a never-written store entry has no defined value: skip it
            for (int k = 0; k < 3; k++) begin
               if (s.pos_known && rsp_tdata[10 + 32*k +: 32] !== s.pos[k])
                  report($sformatf("pos[%0d] of particle %0d", k, s.index), s.pos[k],
                         rsp_tdata[10 + 32*k +: 32]);
               if (s.vel_known && rsp_tdata[106 + 32*k +: 32] !== s.vel[k])
                  report($sformatf("vel[%0d] of particle %0d", k, s.index), s.vel[k],
                         rsp_tdata[106 + 32*k +: 32]);
            end
         end
      end
      pending = state_queue.size();
   end

endmodule

FILE: verif/particle_leapfrog_integrator_tb.sv
`timescale 1ns / 1ps

module particle_leapfrog_integrator_tb;

   localparam int RANDOM_ITEMS = 530;
   localparam int POOL         = 16;   // particles most random traffic works on
   localparam logic [30:0] ONE = 31'h10000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [175:0] req_tdata = '0;   // cmd, particle_index, vec_x..z, time_step, prev_step
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [207:0] rsp_tdata;        // out_index, pos_x..z, vel_x..z

   int fail_count, pending;
   int cmd_seen [4];
   int send_idle_pct = 9;
   int recv_idle_pct = 64;
   logic hold_off = 1'b0;

   // which particles already hold a written position and velocity
   logic pos_written [1024];
   logic vel_written [1024];

   always #5 clock = ~clock;

   particle_leapfrog_integrator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   particle_leapfrog_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending),
      .cmd_seen   (cmd_seen)
   );

   // receiver: random back-pressure, or a full hold during a long stall
   always @(posedge clock) begin
      rsp_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   // offer one transfer, hold it until taken, then maybe leave a gap
   task automatic send(pli_pkg::cmd_type cmd, int idx, logic [31:0] vx, logic [31:0] vy,
                       logic [31:0] vz, logic [30:0] dt, logic [30:0] prev);
      logic taken;
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, prev, dt, vz, vy, vx, 10'(idx), cmd};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      if (cmd == pli_pkg::CMD_LOAD_POS) pos_written[idx] = 1'b1;
      if (cmd == pli_pkg::CMD_LOAD_VEL) vel_written[idx] = 1'b1;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_vec();
      case ($urandom_range(7))
         0:       return 32'h7fffffff;
         1:       return 32'h80000000;
         2:       return $urandom();
         3:       return 32'($signed($urandom_range(0, 16'hffff)) - 32'sd32768);
         default: return 32'($signed($urandom_range(0, 24'hffffff)) - 32'sd8388608);
      endcase
   endfunction

   function automatic logic [30:0] pick_step();
      case ($urandom_range(9))
         0:       return '0;
         1:       return 31'h7fffffff;
         2:       return 31'($urandom());
         3:       return 31'($urandom_range(1, 255));
         default: return 31'($urandom_range(ONE / 64, ONE * 2));
      endcase
   endfunction

   task automatic send_random();
      int               idx;
      pli_pkg::cmd_type cmd;
      idx = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(POOL - 1);
      // a particle without position and velocity only gets loads
      if (!pos_written[idx]) cmd = pli_pkg::CMD_LOAD_POS;
      else if (!vel_written[idx]) cmd = pli_pkg::CMD_LOAD_VEL;
      else begin
         case ($urandom_range(9))
            0, 1, 2: cmd = pli_pkg::CMD_SET_ACCEL;
            3:       cmd = pli_pkg::CMD_LOAD_POS;
            4:       cmd = pli_pkg::CMD_LOAD_VEL;
            default: cmd = pli_pkg::CMD_ADVANCE;
         endcase
      end
      send(cmd, idx, pick_vec(), pick_vec(), pick_vec(), pick_step(), pick_step());
   endtask

   initial begin
      for (int i = 0; i < 1024; i++) begin
         pos_written[i] = 1'b0;
         vel_written[i] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of every field and each special case
      send(pli_pkg::CMD_LOAD_POS, 0, 32'h7fffffff, 32'h80000000, 32'h0, ONE, 0);
      send(pli_pkg::CMD_LOAD_VEL, 0, 32'h7fffffff, 32'h80000000, 32'h1, ONE, 0);
      send(pli_pkg::CMD_ADVANCE, 0, 0, 0, 0, 31'h7fffffff, 31'h7fffffff);      // saturate
      send(pli_pkg::CMD_LOAD_POS, 1023, 32'hffffffff, 32'h00010000, 32'hffff0000, 1, 1);
      send(pli_pkg::CMD_LOAD_VEL, 1023, 32'h55555555, 32'haaaaaaaa, 32'h00008000, 1, 1);
      send(pli_pkg::CMD_SET_ACCEL, 1023, 32'h7fffffff, 32'h80000000, 32'h00010000, 1, 0);
      send(pli_pkg::CMD_ADVANCE, 1023, 0, 0, 0, 1, 0);
      send(pli_pkg::CMD_SET_ACCEL, 1023, 32'h80000000, 32'h7fffffff, 32'h0, 31'h7fffffff, 0);
      send(pli_pkg::CMD_SET_ACCEL, 1023, 32'h00020000, 32'hfffe0000, 32'h1, 0, 0);  // zero step
      send(pli_pkg::CMD_ADVANCE, 1023, 0, 0, 0, 0, 0);                          // zero steps
      send(pli_pkg::CMD_SET_ACCEL, 0, 32'h00020000, 32'hfffd0000, 32'h00008000, ONE, 0);
      send(pli_pkg::CMD_ADVANCE, 0, 0, 0, 0, ONE, ONE);
      send(pli_pkg::CMD_ADVANCE, 0, 0, 0, 0, ONE / 2, 0);
      send(pli_pkg::CMD_ADVANCE, 0, 0, 0, 0, 0, ONE);
      send(pli_pkg::CMD_LOAD_POS, 512, 32'hffff8000, 32'h00008000, 32'h00018000, ONE, ONE);
      send(pli_pkg::CMD_LOAD_VEL, 512, 32'hffff8000, 32'h00008000, 32'hfffe8000, ONE, ONE);
      send(pli_pkg::CMD_ADVANCE, 512, 0, 0, 0, 31'h2aaaaaaa, 31'h55555555);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 64;
            recv_idle_pct = 9;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_random();
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d set-accel, %0d advance, %0d load-pos, %0d load-vel transfers",
               cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
      $display("with sender and receiver idling in turn and one long response stall");
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // long receiver stall while the sender keeps offering: block must back up
   initial begin
      int held;
      held = 0;
      wait (cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3] > 400);
      @(posedge clock);
      hold_off <= 1'b1;
      while (held < 400) begin
         @(posedge clock);
         held++;
      end
      hold_off <= 1'b0;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

endmodule
